// ===== src/thsh_pkg.sv =====
package thsh_pkg;

	// Corner height width, signed Q4.12 at 16 bits
	localparam int HEIGHT_WIDTH = 16;
	localparam int SUN_W        = 16;
	localparam int CFG_IDX_W    = 2;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SUN_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUN_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SUN_Z = 2'd2;

	localparam logic signed [SUN_W-1:0] SUN_X_RST = 16'sd8192;
	localparam logic signed [SUN_W-1:0] SUN_Y_RST = -16'sd8192;
	localparam logic signed [SUN_W-1:0] SUN_Z_RST = 16'sd11585;

	// Gradient, numerator and norm widths
	localparam int GRAD_W = HEIGHT_WIDTH + 2;
	localparam int PROD_W = GRAD_W + SUN_W;
	localparam int NUM_W  = ((PROD_W > 29) ? PROD_W : 29) + 2;
	localparam int SQ_W   = 2 * GRAD_W;
	localparam int Q_W    = ((SQ_W > 26) ? SQ_W : 26) + 2;
	localparam int A_W    = Q_W + 26;

	// Scaled numerator 255*num and its square in two halves
	localparam int MAG_W  = NUM_W - 1;
	localparam int M_W    = MAG_W + 8;
	localparam int ML_W   = M_W / 2;
	localparam int MH_W   = M_W - ML_W;
	localparam int B_W    = 2 * M_W;
	localparam int R_W    = ((B_W > A_W + 18) ? B_W : A_W + 18) + 3;

	localparam int LEVEL_W = 8;

endpackage

// ===== src/thsh_if.sv =====
interface thsh_cell_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [thsh_pkg::HEIGHT_WIDTH-1:0] height_nw;
	logic signed [thsh_pkg::HEIGHT_WIDTH-1:0] height_ne;
	logic signed [thsh_pkg::HEIGHT_WIDTH-1:0] height_sw;
	logic signed [thsh_pkg::HEIGHT_WIDTH-1:0] height_se;

	modport source (output valid, height_nw, height_ne, height_sw, height_se, input ready);
	modport sink (input valid, height_nw, height_ne, height_sw, height_se, output ready);
endinterface

interface thsh_shade_if;
	logic                               valid;
	logic                               ready;
	logic [thsh_pkg::LEVEL_W-1:0]       shade_level;

	modport source (output valid, shade_level, input ready);
	modport sink (input valid, shade_level, output ready);
endinterface

// ===== src/terrain_hillshade_cell.sv =====
// Lambertian hillshade of one raster cell. Each transaction on cell_in carries the four
// corner heights; one transaction on shade_out returns the grey level 0..255 for it. The
// block is a 13-stage pipeline that takes one cell per clock; the whole pipeline holds while a
// finished result is not taken. The level is exact: the final eight stages run a bitwise
// search on squared integers, one level bit per stage, so no square root or divider is used.
// Sun direction words (Q1.14) must be written through cfg_we/cfg_index/cfg_data only while
// the pipeline is empty; the block itself does not enforce this.
module terrain_hillshade_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [thsh_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [thsh_pkg::SUN_W-1:0]          cfg_data,
	thsh_cell_if.sink                           cell_in,
	thsh_shade_if.source                        shade_out
);

	localparam int GW = thsh_pkg::GRAD_W;
	localparam int RW = thsh_pkg::R_W;

	logic signed [thsh_pkg::SUN_W-1:0] sun_x_q, sun_y_q, sun_z_q;

	logic en;

	logic                           v_s1, v_s2, v_s3, v_s4;
	logic signed [GW-1:0]           gx_s1, gy_s1;
	logic signed [thsh_pkg::PROD_W-1:0] px_s2, py_s2;
	logic [thsh_pkg::SQ_W-1:0]      sqx_s2, sqy_s2;
	logic [thsh_pkg::M_W-1:0]       m_s3;
	logic                           pos_s3;
	logic [thsh_pkg::Q_W-1:0]       q_s3;
	logic [2*thsh_pkg::MH_W-1:0]    hh_s4;
	logic [thsh_pkg::M_W-1:0]       hl_s4;
	logic [2*thsh_pkg::ML_W-1:0]    ll_s4;
	logic [thsh_pkg::A_W-1:0]       a_s4;

	logic signed [thsh_pkg::NUM_W-1:0] num_c;
	logic [thsh_pkg::MH_W-1:0]         m_hi;
	logic [thsh_pkg::ML_W-1:0]         m_lo;

	// Search stages: index 0 is the seed stage, index j+1 follows bit stage j
	logic                           srch_v [0:8];
	logic signed [RW-1:0]           srch_r [0:8];
	logic signed [RW-1:0]           srch_p [0:8];
	logic signed [RW-1:0]           srch_a [0:8];
	logic [thsh_pkg::LEVEL_W-1:0]   srch_k [0:8];
	logic signed [RW-1:0]           diff   [0:7];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sun_x_q <= thsh_pkg::SUN_X_RST;
			sun_y_q <= thsh_pkg::SUN_Y_RST;
			sun_z_q <= thsh_pkg::SUN_Z_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				thsh_pkg::REG_SUN_X: sun_x_q <= cfg_data;
				thsh_pkg::REG_SUN_Y: sun_y_q <= cfg_data;
				thsh_pkg::REG_SUN_Z: sun_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the whole pipeline unless the output transaction is held
	assign en = !srch_v[8] || shade_out.ready;
	assign cell_in.ready = en;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int j = 0; j <= 8; j++) srch_v[j] <= 1'b0;
		end else if (en) begin
			v_s1 <= cell_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			srch_v[0] <= v_s4;
			for (int j = 0; j < 8; j++) srch_v[j+1] <= srch_v[j];
		end
	end

	assign num_c = (thsh_pkg::NUM_W'(sun_z_q) <<< 13)
		- thsh_pkg::NUM_W'(px_s2) - thsh_pkg::NUM_W'(py_s2);
	assign m_hi = m_s3[thsh_pkg::M_W-1:thsh_pkg::ML_W];
	assign m_lo = m_s3[thsh_pkg::ML_W-1:0];

	// Front stages: gradients, products, numerator, square of 255*num
	always_ff @(posedge clk) begin
		if (en) begin
			gx_s1 <= (GW'(cell_in.height_ne) + GW'(cell_in.height_se))
				- (GW'(cell_in.height_nw) + GW'(cell_in.height_sw));
			gy_s1 <= (GW'(cell_in.height_sw) + GW'(cell_in.height_se))
				- (GW'(cell_in.height_nw) + GW'(cell_in.height_ne));

			px_s2  <= thsh_pkg::PROD_W'(gx_s1) * thsh_pkg::PROD_W'(sun_x_q);
			py_s2  <= thsh_pkg::PROD_W'(gy_s1) * thsh_pkg::PROD_W'(sun_y_q);
			sqx_s2 <= thsh_pkg::SQ_W'(gx_s1) * thsh_pkg::SQ_W'(gx_s1);
			sqy_s2 <= thsh_pkg::SQ_W'(gy_s1) * thsh_pkg::SQ_W'(gy_s1);

			pos_s3 <= num_c > 0;
			m_s3   <= (num_c > 0) ?
				(thsh_pkg::M_W'(num_c[thsh_pkg::MAG_W-1:0]) << 8)
				- thsh_pkg::M_W'(num_c[thsh_pkg::MAG_W-1:0]) : '0;
			q_s3   <= thsh_pkg::Q_W'(sqx_s2) + thsh_pkg::Q_W'(sqy_s2)
				+ (thsh_pkg::Q_W'(1) << 26);

			hh_s4 <= m_hi * m_hi;
			hl_s4 <= thsh_pkg::M_W'(m_hi) * thsh_pkg::M_W'(m_lo);
			ll_s4 <= m_lo * m_lo;
			a_s4  <= thsh_pkg::A_W'(q_s3) << 26;
		end
	end

	// Trial subtraction for each level bit, most significant first
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			diff[j] = srch_r[j] - ((srch_p[j] <<< (2 + 7 - j))
				+ (srch_a[j] <<< (2 + 2*(7 - j))));
		end
	end

	// Seed the search with R = B - A, P = -A for level zero, then keep the bit
	// where the remainder stays non-negative
	always_ff @(posedge clk) begin
		if (en) begin
			srch_r[0] <= (RW'(hh_s4) << (2*thsh_pkg::ML_W)) + (RW'(hl_s4) << (thsh_pkg::ML_W+1))
				+ RW'(ll_s4) - RW'(a_s4);
			srch_p[0] <= -RW'(a_s4);
			srch_a[0] <= RW'(a_s4);
			srch_k[0] <= '0;
			for (int j = 0; j < 8; j++) begin
				srch_a[j+1] <= srch_a[j];
				if (!diff[j][RW-1]) begin
					srch_r[j+1] <= diff[j];
					srch_p[j+1] <= srch_p[j] + (srch_a[j] <<< (1 + 7 - j));
					srch_k[j+1] <= srch_k[j] | (thsh_pkg::LEVEL_W'(1) << (7 - j));
				end else begin
					srch_r[j+1] <= srch_r[j];
					srch_p[j+1] <= srch_p[j];
					srch_k[j+1] <= srch_k[j];
				end
			end
		end
	end

	assign shade_out.valid       = srch_v[8];
	assign shade_out.shade_level = srch_k[8];

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_in.valid && cell_in.ready) |=> v_s1)
		else $error("accepted cell did not enter stage 1");

	a_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !pos_s3) |-> (m_s3 == '0))
		else $error("unlit cell carries a nonzero numerator");

	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(srch_v[8] && srch_k[8] != '0) |-> !srch_r[8][RW-1])
		else $error("search remainder negative for a lit level");

endmodule

// ===== tb/sv/tb_terrain_hillshade_cell.sv =====
`timescale 1ns / 1ps

module tb_terrain_hillshade_cell;

	typedef struct packed {
		logic signed [thsh_pkg::HEIGHT_WIDTH-1:0] nw;
		logic signed [thsh_pkg::HEIGHT_WIDTH-1:0] ne;
		logic signed [thsh_pkg::HEIGHT_WIDTH-1:0] sw;
		logic signed [thsh_pkg::HEIGHT_WIDTH-1:0] se;
	} corners_t;

	// Index with no register behind it
	localparam logic [thsh_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

	// Expected shade levels in arrival order, with the sun direction in force
	class shade_ledger;
		logic signed [thsh_pkg::SUN_W-1:0] sun_x = thsh_pkg::SUN_X_RST;
		logic signed [thsh_pkg::SUN_W-1:0] sun_y = thsh_pkg::SUN_Y_RST;
		logic signed [thsh_pkg::SUN_W-1:0] sun_z = thsh_pkg::SUN_Z_RST;
		logic [thsh_pkg::LEVEL_W-1:0] pending_levels[$];

		function void set_sun(logic [thsh_pkg::CFG_IDX_W-1:0] idx,
				logic [thsh_pkg::SUN_W-1:0] word);
			case (idx)
				thsh_pkg::REG_SUN_X: sun_x = word;
				thsh_pkg::REG_SUN_Y: sun_y = word;
				thsh_pkg::REG_SUN_Z: sun_z = word;
				default: ;
			endcase
		endfunction

		// Largest k with (2k-1)^2 * 2^28 * Q <= 510^2 * N^2, in squared integers
		function logic [thsh_pkg::LEVEL_W-1:0] lit_level(corners_t c);
			longint gx, gy, num, odd;
			logic [127:0] q, rhs, lhs;
			gx = (longint'(c.ne) + longint'(c.se)) - (longint'(c.nw) + longint'(c.sw));
			gy = (longint'(c.sw) + longint'(c.se)) - (longint'(c.nw) + longint'(c.ne));
			num = longint'(sun_z) * 8192 - gx * longint'(sun_x) - gy * longint'(sun_y);
			if (num <= 0)
				return '0;
			q = 128'(gx * gx) + 128'(gy * gy) + (128'd1 << 26);
			rhs = 128'(num);
			rhs = rhs * rhs * 128'd260100;
			for (int k = 255; k >= 1; k--) begin
				odd = 2 * k - 1;
				lhs = (q * 128'(odd * odd)) << 28;
				if (lhs <= rhs)
					return thsh_pkg::LEVEL_W'(k);
			end
			return '0;
		endfunction

		function void note_cell(corners_t c);
			pending_levels = {pending_levels, lit_level(c)};
		endfunction

		function bit check_level(logic [thsh_pkg::LEVEL_W-1:0] got, output string why);
			logic [thsh_pkg::LEVEL_W-1:0] want;
			if (pending_levels.size() == 0) begin
				why = $sformatf("shade_level %0d arrived with nothing expected", got);
				return 0;
			end
			want = pending_levels.pop_front();
			if (got !== want) begin
				why = $sformatf("shade_level %0d, expected %0d", got, want);
				return 0;
			end
			return 1;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [thsh_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [thsh_pkg::SUN_W-1:0] cfg_data;

	thsh_cell_if cell_in();
	thsh_shade_if shade_out();

	terrain_hillshade_cell i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cell_in(cell_in.sink),
		.shade_out(shade_out.source)
	);

	shade_ledger ledger = new();
	int mismatches = 0;
	int gap_pct = 0;
	int stall_pct = 0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic report(string why);
		$display("%0t mismatch: %s", $realtime, why);
		mismatches++;
	endtask

	// Check each shade transaction and choose the next ready
	always @(posedge clk) begin
		string why;
		if (arst_n && shade_out.valid && shade_out.ready) begin
			if (!ledger.check_level(shade_out.shade_level, why))
				report(why);
		end
		shade_out.ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	task automatic write_sun(logic [thsh_pkg::CFG_IDX_W-1:0] idx,
			logic [thsh_pkg::SUN_W-1:0] word);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= word;
		@(posedge clk);
		cfg_we <= 1'b0;
		ledger.set_sun(idx, word);
	endtask

	task automatic send_cell(corners_t c);
		// hold valid low for a random gap, then present the cell until taken
		while ($urandom_range(99) < gap_pct) begin
			cell_in.valid <= 1'b0;
			@(posedge clk);
		end
		cell_in.valid <= 1'b1;
		cell_in.height_nw <= c.nw;
		cell_in.height_ne <= c.ne;
		cell_in.height_sw <= c.sw;
		cell_in.height_se <= c.se;
		@(posedge clk);
		while (!cell_in.ready)
			@(posedge clk);
		ledger.note_cell(c);
	endtask

	task automatic send_heights(int nw, int ne, int sw, int se);
		corners_t c;
		c.nw = thsh_pkg::HEIGHT_WIDTH'(nw);
		c.ne = thsh_pkg::HEIGHT_WIDTH'(ne);
		c.sw = thsh_pkg::HEIGHT_WIDTH'(sw);
		c.se = thsh_pkg::HEIGHT_WIDTH'(se);
		send_cell(c);
	endtask

	// Mostly gentle slopes around a random base, the rest any heights at all
	task automatic send_random_cell();
		corners_t c;
		int spread, base;
		if ($urandom_range(99) < 60) begin
			spread = $urandom_range(3) == 0 ? 16384 : int'($urandom_range(4096));
			base = int'($urandom);
			c.nw = thsh_pkg::HEIGHT_WIDTH'(base + int'($urandom_range(2 * spread)) - spread);
			c.ne = thsh_pkg::HEIGHT_WIDTH'(base + int'($urandom_range(2 * spread)) - spread);
			c.sw = thsh_pkg::HEIGHT_WIDTH'(base + int'($urandom_range(2 * spread)) - spread);
			c.se = thsh_pkg::HEIGHT_WIDTH'(base + int'($urandom_range(2 * spread)) - spread);
		end else begin
			c = {$urandom, $urandom};
		end
		send_cell(c);
	endtask

	// Empty the pipeline before touching the sun registers
	task automatic drain();
		cell_in.valid <= 1'b0;
		while (ledger.pending_levels.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_sun();
		write_sun(thsh_pkg::REG_SUN_X, thsh_pkg::SUN_W'($urandom_range(32768) - 16384));
		write_sun(thsh_pkg::REG_SUN_Y, thsh_pkg::SUN_W'($urandom_range(32768) - 16384));
		write_sun(thsh_pkg::REG_SUN_Z, thsh_pkg::SUN_W'($urandom_range(16384)));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cell_in.valid = 1'b0;
		cell_in.height_nw = '0;
		cell_in.height_ne = '0;
		cell_in.height_sw = '0;
		cell_in.height_se = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cells under the reset sun
		send_heights(0, 0, 0, 0);
		send_heights(32767, 32767, 32767, 32767);
		send_heights(-32768, -32768, -32768, -32768);
		send_heights(-32768, 32767, -32768, 32767);
		send_heights(32767, -32768, 32767, -32768);
		send_heights(-32768, -32768, 32767, 32767);
		send_heights(32767, 32767, -32768, -32768);
		send_heights(-32768, 32767, 32767, -32768);
		send_heights(0, 4096, 0, 4096);
		send_heights(4096, 0, 4096, 0);
		send_heights(0, 0, 4096, 4096);
		send_heights(100, -200, 300, -400);
		send_heights(21845, -21846, 0, 1);
		drain();

		// Unknown index is ignored; a sun with Z at 1.0 on a flat cell is fully lit
		write_sun(REG_NONE, 16'h1234);
		send_heights(0, 0, 0, 0);
		drain();
		write_sun(thsh_pkg::REG_SUN_X, thsh_pkg::SUN_W'(-16384));
		write_sun(thsh_pkg::REG_SUN_Y, thsh_pkg::SUN_W'(16384));
		write_sun(thsh_pkg::REG_SUN_Z, thsh_pkg::SUN_W'(16384));
		send_heights(0, 0, 0, 0);
		send_heights(0, -8192, 0, -8192);
		send_heights(0, 0, -8192, -8192);
		send_heights(0, 8192, 8192, 16384);
		drain();
		// Out-of-range words and a sun on the horizon
		write_sun(thsh_pkg::REG_SUN_X, 16'h7fff);
		write_sun(thsh_pkg::REG_SUN_Y, 16'h8000);
		write_sun(thsh_pkg::REG_SUN_Z, 16'h0000);
		send_heights(0, 0, 0, 0);
		send_heights(0, -4096, 4096, 0);
		send_heights(0, -32768, 32767, 0);
		drain();

		// Random cells across the idling phases, new sun each stretch
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 67; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 67; end
				default: begin gap_pct = 9; stall_pct = 9; end
			endcase
			for (int part = 0; part < 3; part++) begin
				if (phase == 0 && part == 0) begin
					write_sun(thsh_pkg::REG_SUN_X, thsh_pkg::SUN_X_RST);
					write_sun(thsh_pkg::REG_SUN_Y, thsh_pkg::SUN_Y_RST);
					write_sun(thsh_pkg::REG_SUN_Z, thsh_pkg::SUN_Z_RST);
				end else if (phase == 3 && part == 2) begin
					write_sun(thsh_pkg::REG_SUN_X, thsh_pkg::SUN_W'($urandom));
					write_sun(thsh_pkg::REG_SUN_Y, thsh_pkg::SUN_W'($urandom));
					write_sun(thsh_pkg::REG_SUN_Z, thsh_pkg::SUN_W'($urandom));
				end else begin
					random_sun();
				end
				for (int n = 0; n < 50; n++)
					send_random_cell();
				drain();
			end
		end

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
src/thsh_pkg.sv
src/thsh_if.sv
src/terrain_hillshade_cell.sv
tb/sv/tb_terrain_hillshade_cell.sv
